>>> sv/n_run_gap_contig_splitter_defines.svh
// Assertion macros for the N-run gap/contig splitter.
// Depends on aclk and aresetn being in scope where a macro is used.
`ifndef N_RUN_GAP_CONTIG_SPLITTER_DEFINES_SVH
`define N_RUN_GAP_CONTIG_SPLITTER_DEFINES_SVH
`ifndef SYNTH
`define NRGCS_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("nrgcs assertion failed");
`define NRGCS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("nrgcs assertion failed");
`else
`define NRGCS_ASSERT_SAME(label, pre, post)
`define NRGCS_ASSERT_NEXT(label, pre, post)
`endif
`endif

>>> sv/nrgcs_pkg.sv
// Shared types, constants and helper functions of the N-run gap/contig splitter.
// No dependencies.
package nrgcs_pkg;

    localparam int POSITION_BITS = 32;
    localparam int FIELD_W       = 32;
    localparam int MIN_LEN_W     = 16;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    localparam logic [7:0] CHAR_N       = 8'h4E;
    localparam logic [7:0] CHAR_N_LOWER = 8'h6E;

    typedef enum logic {
        KIND_GAP    = 1'b0,
        KIND_CONTIG = 1'b1
    } record_kind_t;

    typedef struct packed {
        record_kind_t         kind;
        logic [FIELD_W-1:0]   start;
        logic [FIELD_W-1:0]   length;
        logic                 last;
    } record_t;

    typedef struct packed {
        logic    push0;
        logic    push1;
        record_t rec0;
        record_t rec1;
    } rec_push_t;

    function automatic logic [POSITION_BITS-1:0] sat_pos(input logic [POSITION_BITS+1:0] v);
        logic [POSITION_BITS-1:0] r;
        if (v > {2'b00, POS_MAX}) begin
            r = POS_MAX;
        end else begin
            r = v[POSITION_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input logic [POSITION_BITS+1:0] v);
        logic [POSITION_BITS+FIELD_W-1:0] w;
        w = (POSITION_BITS+FIELD_W)'(sat_pos(v));
        return w[FIELD_W-1:0];
    endfunction

endpackage

>>> sv/nrgcs_rec_fifo.sv
// Record queue of the splitter: takes up to two records per cycle, hands out one per transfer.
// Depends on nrgcs_pkg.
module nrgcs_rec_fifo
    import nrgcs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  rec_push_t push,
    output logic      room,
    output logic      m_valid,
    input  logic      m_ready,
    output record_t   head
);

    record_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic                 pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign room    = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign head    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.push0) + FIFO_AW'(push.push1);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push.push0) + FIFO_CW'(push.push1)
                      - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.push0) begin
            mem_reg[wr_ptr_reg] <= push.rec0;
        end
        if (push.push1) begin
            mem_reg[FIFO_AW'(wr_ptr_reg + 1'b1)] <= push.rec1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/n_run_gap_contig_splitter.sv
// N-run gap/contig splitter, top level. Takes one base per cycle while the record queue
// has room and writes gap and contig records (start, length) in position order. Depends
// on nrgcs_pkg, nrgcs_rec_fifo and n_run_gap_contig_splitter_defines.svh.
// A base is registered on transfer and resolved from that register against the run
// state; its records (at most two) go into a four-entry record queue. A new base is
// taken every cycle while the queue holds two or fewer records, so the sustained rate
// is one base per cycle, bounded by the record port draining one record per cycle.
// The user must write min_contig_length through the cfg port only while the block
// is idle; the block does not enforce it. Positions saturate at 2^32-1.
`include "n_run_gap_contig_splitter_defines.svh"
module n_run_gap_contig_splitter
    import nrgcs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [MIN_LEN_W-1:0] cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_base,
    input  logic                 s_end_of_scaffold,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_record_kind,
    output logic [FIELD_W-1:0]   m_start_position,
    output logic [FIELD_W-1:0]   m_region_length,
    output logic                 m_last_of_scaffold
);

    localparam int PB = POSITION_BITS;

    logic [MIN_LEN_W-1:0] min_len_reg;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_base_reg;
    logic       in_eos_reg;

    logic [PB-1:0] position_reg, position_next;
    logic          run_is_gap_reg, run_is_gap_next;
    logic [PB-1:0] run_start_reg, run_start_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [PB-1:0] pend_start_reg, pend_start_next;
    logic [PB-1:0] pend_len_reg, pend_len_next;
    logic          seen_long_reg, seen_long_next;

    logic          fire, room;
    logic          is_n;
    logic [PB:0]   end_pos;
    logic [PB:0]   close_len;
    logic [PB:0]   min_ext;
    logic [1:0]    n_rec;
    logic          rg, pv, seen;
    logic [PB-1:0] rs, ps, pl;
    record_t       recs [2];
    rec_push_t     push;
    record_t       head;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && room;
    assign s_ready   = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            min_len_reg <= cfg_data;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_base_reg <= s_base;
            in_eos_reg  <= s_end_of_scaffold;
        end
    end

    // resolve one base against the run state
    always_comb begin
        is_n      = (in_base_reg == CHAR_N) || (in_base_reg == CHAR_N_LOWER);
        end_pos   = {1'b0, position_reg} + (PB+1)'(1);
        min_ext   = (PB+1)'(min_len_reg);
        rg        = run_is_gap_reg;
        rs        = run_start_reg;
        pv        = pend_valid_reg;
        ps        = pend_start_reg;
        pl        = pend_len_reg;
        seen      = seen_long_reg;
        n_rec     = '0;
        close_len = '0;
        recs[0]   = '0;
        recs[1]   = '0;

        if (position_reg == '0) begin
            rg = is_n;
            rs = '0;
        end else if (is_n != rg) begin
            close_len = {1'b0, position_reg - rs};
            if (rg || (close_len < min_ext)) begin
                if (pv) begin
                    pl = sat_pos((PB+2)'(pl) + (PB+2)'(close_len));
                end else begin
                    pv = 1'b1;
                    ps = rs;
                    pl = sat_pos((PB+2)'(close_len));
                end
            end else if (n_rec < 2'd2) begin
                recs[n_rec[0]] = '{KIND_CONTIG, to_field((PB+2)'(rs)),
                                   to_field((PB+2)'(close_len)), 1'b0};
                n_rec = n_rec + 2'd1;
            end
            rg = is_n;
            rs = position_reg;
        end

        if (!rg && ((end_pos - (PB+1)'(rs)) >= min_ext)) begin
            seen = 1'b1;
            if (pv) begin
                if (n_rec < 2'd2) begin
                    recs[n_rec[0]] = '{KIND_GAP, to_field((PB+2)'(ps)),
                                       to_field((PB+2)'(pl)), 1'b0};
                    n_rec = n_rec + 2'd1;
                end
                pv = 1'b0;
            end
        end

        if (in_eos_reg) begin
            close_len = end_pos - (PB+1)'(rs);
            if (rg || (close_len < min_ext)) begin
                if (pv) begin
                    pl = sat_pos((PB+2)'(pl) + (PB+2)'(close_len));
                end else begin
                    pv = 1'b1;
                    ps = rs;
                    pl = sat_pos((PB+2)'(close_len));
                end
            end else if (n_rec < 2'd2) begin
                recs[n_rec[0]] = '{KIND_CONTIG, to_field((PB+2)'(rs)),
                                   to_field((PB+2)'(close_len)), 1'b0};
                n_rec = n_rec + 2'd1;
            end
            if (pv && (n_rec < 2'd2)) begin
                priority if (seen) begin
                    recs[n_rec[0]] = '{KIND_GAP, to_field((PB+2)'(ps)),
                                       to_field((PB+2)'(pl)), 1'b0};
                end else if (rg && (rs == '0)) begin
                    recs[n_rec[0]] = '{KIND_GAP, '0, to_field((PB+2)'(end_pos)), 1'b0};
                end else begin
                    recs[n_rec[0]] = '{KIND_CONTIG, '0, to_field((PB+2)'(end_pos)), 1'b0};
                end
                n_rec = n_rec + 2'd1;
            end
            if (n_rec == 2'd1) begin
                recs[0].last = 1'b1;
            end else if (n_rec == 2'd2) begin
                recs[1].last = 1'b1;
            end
        end
    end

    always_comb begin
        position_next   = position_reg;
        run_is_gap_next = run_is_gap_reg;
        run_start_next  = run_start_reg;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_len_next   = pend_len_reg;
        seen_long_next  = seen_long_reg;
        if (fire) begin
            if (in_eos_reg) begin
                position_next   = '0;
                run_is_gap_next = 1'b0;
                run_start_next  = '0;
                pend_valid_next = 1'b0;
                pend_start_next = '0;
                pend_len_next   = '0;
                seen_long_next  = 1'b0;
            end else begin
                position_next   = sat_pos((PB+2)'(end_pos));
                run_is_gap_next = rg;
                run_start_next  = rs;
                pend_valid_next = pv;
                pend_start_next = ps;
                pend_len_next   = pl;
                seen_long_next  = seen;
            end
        end
    end

    always_comb begin
        push.push0 = fire && (n_rec != 2'd0);
        push.push1 = fire && (n_rec == 2'd2);
        push.rec0  = recs[0];
        push.rec1  = recs[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            position_reg   <= '0;
            run_is_gap_reg <= 1'b0;
            run_start_reg  <= '0;
            pend_valid_reg <= 1'b0;
            pend_start_reg <= '0;
            pend_len_reg   <= '0;
            seen_long_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            position_reg   <= position_next;
            run_is_gap_reg <= run_is_gap_next;
            run_start_reg  <= run_start_next;
            pend_valid_reg <= pend_valid_next;
            pend_start_reg <= pend_start_next;
            pend_len_reg   <= pend_len_next;
            seen_long_reg  <= seen_long_next;
        end
    end

    nrgcs_rec_fifo u_rec_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_record_kind      = head.kind;
    assign m_start_position   = head.start;
    assign m_region_length    = head.length;
    assign m_last_of_scaffold = head.last;

    `NRGCS_ASSERT_SAME(a_eos_yields_record, fire && in_eos_reg, push.push0)
    `NRGCS_ASSERT_SAME(a_last_only_on_eos, push.push0 && (recs[0].last || recs[1].last), in_eos_reg)
    `NRGCS_ASSERT_NEXT(a_eos_restarts, fire && in_eos_reg, position_reg == '0 && !pend_valid_reg)

endmodule
